### hw/rtl/assert_macros.svh
// assertion macros used by the converter top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define C2S_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define C2S_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define C2S_ASSERT(lbl, clk, rst_n, prop, msg)
`define C2S_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### hw/rtl/c2s_pkg.sv
// shared constants, types and the cordic arctangent table
package c2s_pkg;

  localparam int GUARD_BITS = 24;
  localparam int ACC_W      = 34;
  localparam int RADIUS_W   = 32;

  // pi in accumulator units of pi/2^31
  localparam logic signed [ACC_W-1:0] HALF_TURN = 34'sh0_8000_0000;

  typedef struct packed {
    logic y_zero;
    logic x_neg;
    logic z_neg;
    logic z_zero;
    logic xy_zero;
  } pt_flags_t;

  // atan(2^-idx) in units of pi/2^31
  function automatic logic [31:0] atan_step(input int unsigned idx);
    logic [31:0] v;
    case (idx)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051E;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2F9;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/cartesian_to_spherical_top.sv
// cartesian to spherical converter: radius, azimuth and inclination per point
//
//   channel  direction  signals
//   in       input      in_valid_i / in_ready_o, x_coord_i, y_coord_i, z_coord_i
//   out      output     out_valid_o / out_ready_i, radius_o, azimuth_o,
//                       inclination_o, degenerate_o
//
// one point per cycle sustained while the output is not stalled; a point passes 3 front
// stages, the queue, COORD_WIDTH square root stages, CORDIC_STAGES + 1 cordic stages
// and the output register; the root and cordic pipelines make up most of the depth.
// reset clears only valid bits and the queue pointers and count. a stall at
// the output freezes the back pipeline; the front keeps filling the two-entry
// queue and stalls in turn once it is full.
`include "assert_macros.svh"

module cartesian_to_spherical_top import c2s_pkg::*; #(
  parameter int COORD_WIDTH   = 32,
  parameter int ANGLE_WIDTH   = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] x_coord_i,
  input  logic signed [COORD_WIDTH-1:0] y_coord_i,
  input  logic signed [COORD_WIDTH-1:0] z_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [RADIUS_W-1:0]           radius_o,
  output logic signed [ANGLE_WIDTH-1:0] azimuth_o,
  output logic [ANGLE_WIDTH-1:0]        inclination_o,
  output logic                          degenerate_o
);

  localparam int W      = COORD_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int FW     = $bits(pt_flags_t);
  localparam int DW     = 4 * W + 3 * W + FW;
  localparam int QDEPTH = 2;
  localparam int SQ_LAT = W;
  localparam int CD_LAT = CORDIC_STAGES + 1;
  localparam int BK_LAT = SQ_LAT + CD_LAT;

  // rounding offset: half an output lsb in accumulator units
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(64'd1 << (31 - AW));
  localparam logic [AW-1:0] HALF_ANG = {1'b1, {(AW-1){1'b0}}};

  // front to queue
  logic           f_valid, q_push_ready;
  logic [2*W-1:0] f_sum3, f_sqxy;
  logic signed [W-1:0] f_x, f_y, f_z;
  pt_flags_t      f_flags;

  // queue head
  logic           q_valid, q_pop;
  logic [DW-1:0]  q_data;
  logic [2*W-1:0] q_sum3, q_sqxy;
  logic signed [W-1:0] q_x, q_y, q_z;
  pt_flags_t      q_flags;

  // back pipeline
  logic                    en_b;
  logic [BK_LAT-1:0]       vld_q;
  pt_flags_t               flg_q [BK_LAT];
  logic [3*W-1:0]          xyz_q [SQ_LAT];
  logic [W-1:0]            rad_dly_q [CD_LAT];
  logic [W-1:0]            root_r, root_rho;
  logic signed [W-1:0]     d_x, d_y, d_z;
  logic signed [ACC_W-1:0] az_acc, inc_acc;

  // output stage
  pt_flags_t               flg_o;
  logic signed [ACC_W-1:0] az_a, inc_a, az_sum, inc_sum;
  logic [AW-1:0]           azimuth_d, inclination_d;
  logic                    degenerate_d;
  logic                    out_valid_q, degenerate_q;
  logic [RADIUS_W-1:0]     radius_q;
  logic [AW-1:0]           azimuth_q, inclination_q;

  c2s_front #(.W(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .z_coord_i   (z_coord_i),
    .out_valid_o (f_valid),
    .out_ready_i (q_push_ready),
    .sum3_o      (f_sum3),
    .sqxy_o      (f_sqxy),
    .x_o         (f_x),
    .y_o         (f_y),
    .z_o         (f_z),
    .flags_o     (f_flags)
  );

  c2s_queue #(.DW(DW), .DEPTH(QDEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (q_push_ready),
    .push_data_i  ({f_sum3, f_sqxy, f_x, f_y, f_z, f_flags}),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (en_b),
    .pop_data_o   (q_data)
  );

  assign {q_sum3, q_sqxy, q_x, q_y, q_z, q_flags} = q_data;

  // whole back end advances together whenever the output slot frees up
  assign en_b  = !out_valid_q || out_ready_i;
  assign q_pop = q_valid && en_b;

  c2s_isqrt #(.W(W)) u_sqrt_r (
    .clk_i  (clk_i),
    .en_i   (en_b),
    .rad_i  (q_sum3),
    .root_o (root_r)
  );

  c2s_isqrt #(.W(W)) u_sqrt_rho (
    .clk_i  (clk_i),
    .en_i   (en_b),
    .rad_i  (q_sqxy),
    .root_o (root_rho)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_b) begin
      vld_q <= {vld_q[BK_LAT-2:0], q_valid};
    end
  end

  // sideband lines matching the root and cordic depths
  always_ff @(posedge clk_i) begin
    if (en_b) begin
      flg_q[0] <= q_flags;
      for (int k = 1; k < BK_LAT; k++) begin
        flg_q[k] <= flg_q[k-1];
      end
      xyz_q[0] <= {q_x, q_y, q_z};
      for (int k = 1; k < SQ_LAT; k++) begin
        xyz_q[k] <= xyz_q[k-1];
      end
      rad_dly_q[0] <= root_r;
      for (int k = 1; k < CD_LAT; k++) begin
        rad_dly_q[k] <= rad_dly_q[k-1];
      end
    end
  end

  assign {d_x, d_y, d_z} = xyz_q[SQ_LAT-1];

  // azimuth from (x, y), inclination from (z, rho)
  c2s_cordic #(.IW(W + 1), .STAGES(CORDIC_STAGES)) u_cordic_az (
    .clk_i (clk_i),
    .en_i  (en_b),
    .px_i  ({d_x[W-1], d_x}),
    .py_i  ({d_y[W-1], d_y}),
    .acc_o (az_acc)
  );

  c2s_cordic #(.IW(W + 1), .STAGES(CORDIC_STAGES)) u_cordic_inc (
    .clk_i (clk_i),
    .en_i  (en_b),
    .px_i  ({d_z[W-1], d_z}),
    .py_i  ({1'b0, root_rho}),
    .acc_o (inc_acc)
  );

  assign flg_o = flg_q[BK_LAT-1];

  always_comb begin
    // points with y zero (the xz plane) take 0 or pi directly
    if (flg_o.y_zero) begin
      az_a = flg_o.x_neg ? HALF_TURN : '0;
    end else begin
      az_a = az_acc;
    end
    // points on the z axis, origin included
    if (flg_o.xy_zero) begin
      inc_a = flg_o.z_neg ? HALF_TURN : '0;
    end else if (inc_acc[ACC_W-1]) begin
      inc_a = '0;
    end else if (inc_acc > HALF_TURN) begin
      inc_a = HALF_TURN;
    end else begin
      inc_a = inc_acc;
    end
    az_sum        = az_a + RND;
    inc_sum       = inc_a + RND;
    azimuth_d     = az_sum[32-AW +: AW];
    inclination_d = inc_sum[32-AW +: AW];
    degenerate_d  = flg_o.xy_zero && flg_o.z_zero;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_b) begin
      out_valid_q <= vld_q[BK_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      radius_q      <= RADIUS_W'(rad_dly_q[CD_LAT-1]);
      azimuth_q     <= azimuth_d;
      inclination_q <= inclination_d;
      degenerate_q  <= degenerate_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign radius_o      = radius_q;
  assign azimuth_o     = azimuth_q;
  assign inclination_o = inclination_q;
  assign degenerate_o  = degenerate_q;

  // origin reports zero length and zero angles
  `C2S_ASSERT(a_degen_zero, clk_i, rst_ni, out_valid_o && degenerate_o |-> radius_o == '0 && azimuth_o == '0 && inclination_o == '0, "origin result not all zero")
  // inclination never exceeds pi
  `C2S_ASSERT(a_inc_range, clk_i, rst_ni, out_valid_o |-> inclination_o <= HALF_ANG, "inclination above pi")
  // a stalled output never pulls from the queue
  `C2S_ASSERT(a_no_pop_stall, clk_i, rst_ni, out_valid_o && !out_ready_i |-> !q_pop, "queue popped during output stall")
  // front keeps its item while the queue is full
  `C2S_ASSERT_NEXT(a_front_hold, clk_i, rst_ni, f_valid && !q_push_ready, f_valid, "front dropped an item")

endmodule

### hw/rtl/c2s_front.sv
// front end: magnitudes, point classification, squares and sums
module c2s_front import c2s_pkg::*; #(
  parameter int W = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [W-1:0] x_coord_i,
  input  logic signed [W-1:0] y_coord_i,
  input  logic signed [W-1:0] z_coord_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2*W-1:0]      sum3_o,
  output logic [2*W-1:0]      sqxy_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output logic signed [W-1:0] z_o,
  output pt_flags_t           flags_o
);

  logic en;
  logic v1_q, v2_q, v3_q;

  logic [W-1:0] mx_d, my_d, mz_d, mx_q, my_q, mz_q;
  pt_flags_t    flags_d, flags1_q, flags2_q, flags3_q;
  logic signed [W-1:0] x1_q, y1_q, z1_q, x2_q, y2_q, z2_q, x3_q, y3_q, z3_q;
  logic [2*W-1:0] sqx_d, sqy_d, sqz_d, sqx_q, sqy_q, sqz_q;
  logic [2*W-1:0] sqxy_d, sum3_d, sqxy_q, sum3_q;

  assign en         = !v3_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_comb begin
    mx_d = x_coord_i[W-1] ? -x_coord_i : x_coord_i;
    my_d = y_coord_i[W-1] ? -y_coord_i : y_coord_i;
    mz_d = z_coord_i[W-1] ? -z_coord_i : z_coord_i;
    flags_d.y_zero  = (y_coord_i == '0);
    flags_d.x_neg   = x_coord_i[W-1];
    flags_d.z_neg   = z_coord_i[W-1];
    flags_d.z_zero  = (z_coord_i == '0);
    flags_d.xy_zero = (x_coord_i == '0) && (y_coord_i == '0);
  end

  always_comb begin
    sqx_d  = {{W{1'b0}}, mx_q} * {{W{1'b0}}, mx_q};
    sqy_d  = {{W{1'b0}}, my_q} * {{W{1'b0}}, my_q};
    sqz_d  = {{W{1'b0}}, mz_q} * {{W{1'b0}}, mz_q};
    sqxy_d = sqx_q + sqy_q;
    sum3_d = sqx_q + sqy_q + sqz_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q     <= mx_d;
      my_q     <= my_d;
      mz_q     <= mz_d;
      flags1_q <= flags_d;
      x1_q     <= x_coord_i;
      y1_q     <= y_coord_i;
      z1_q     <= z_coord_i;
      sqx_q    <= sqx_d;
      sqy_q    <= sqy_d;
      sqz_q    <= sqz_d;
      flags2_q <= flags1_q;
      x2_q     <= x1_q;
      y2_q     <= y1_q;
      z2_q     <= z1_q;
      sqxy_q   <= sqxy_d;
      sum3_q   <= sum3_d;
      flags3_q <= flags2_q;
      x3_q     <= x2_q;
      y3_q     <= y2_q;
      z3_q     <= z2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign sum3_o      = sum3_q;
  assign sqxy_o      = sqxy_q;
  assign x_o         = x3_q;
  assign y_o         = y3_q;
  assign z_o         = z3_q;
  assign flags_o     = flags3_q;

endmodule

### hw/rtl/c2s_queue.sv
// short flop queue between front and back
module c2s_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  logic [DW-1:0] push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output logic [DW-1:0] pop_data_o
);

  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DW-1:0]   mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CNTW'(DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hw/rtl/c2s_isqrt.sv
// pipelined integer square root, one root bit per stage
module c2s_isqrt #(
  parameter int W = 32
) (
  input  logic           clk_i,
  input  logic           en_i,
  input  logic [2*W-1:0] rad_i,
  output logic [W-1:0]   root_o
);

  localparam int RMW = W + 3;

  logic [2*W-1:0] rad_q  [W];
  logic [RMW-1:0] rem_q  [W];
  logic [W-1:0]   root_q [W];

  for (genvar j = 0; j < W; j++) begin : g_stage
    logic [2*W-1:0] rad_in;
    logic [RMW-1:0] rem_in, tmp, trial;
    logic [W-1:0]   root_in;
    logic           ge;

    if (j == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign tmp   = {rem_in[RMW-4+1:0], rad_in[2*W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[j]  <= {rad_in[2*W-3:0], 2'b00};
        rem_q[j]  <= ge ? (tmp - trial) : tmp;
        root_q[j] <= {root_in[W-2:0], ge};
      end
    end
  end

  assign root_o = root_q[W-1];

endmodule

### hw/rtl/c2s_cordic.sv
// pipelined vectoring cordic, angle accumulator in units of pi/2^31
module c2s_cordic import c2s_pkg::*; #(
  parameter int IW     = 33,
  parameter int STAGES = 16
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IW-1:0]    px_i,
  input  logic signed [IW-1:0]    py_i,
  output logic signed [ACC_W-1:0] acc_o
);

  localparam int CW = IW + 1 + GUARD_BITS;

  logic signed [CW-1:0]    cx_q  [STAGES+1];
  logic signed [CW-1:0]    cy_q  [STAGES+1];
  logic signed [ACC_W-1:0] acc_q [STAGES+1];
  logic signed [CW-1:0]    px_ext, py_ext;

  assign px_ext = {px_i[IW-1], px_i, {GUARD_BITS{1'b0}}};
  assign py_ext = {py_i[IW-1], py_i, {GUARD_BITS{1'b0}}};

  // left half plane folds onto the right one, starting at pi
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cx_q[0]  <= px_i[IW-1] ? -px_ext : px_ext;
      cy_q[0]  <= px_i[IW-1] ? -py_ext : py_ext;
      acc_q[0] <= px_i[IW-1] ? HALF_TURN : '0;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    logic signed [CW-1:0]    dx, dy;
    logic signed [ACC_W-1:0] step;
    assign dx   = cy_q[i] >>> i;
    assign dy   = cx_q[i] >>> i;
    assign step = ACC_W'(atan_step(i));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!cy_q[i][CW-1]) begin
          cx_q[i+1]  <= cx_q[i] + dx;
          cy_q[i+1]  <= cy_q[i] - dy;
          acc_q[i+1] <= acc_q[i] + step;
        end else begin
          cx_q[i+1]  <= cx_q[i] - dx;
          cy_q[i+1]  <= cy_q[i] + dy;
          acc_q[i+1] <= acc_q[i] - step;
        end
      end
    end
  end

  assign acc_o = acc_q[STAGES];

endmodule

### test/cartesian_to_spherical_top_test.sv
// testbench for the cartesian to spherical converter: directed table, then random points
module cartesian_to_spherical_top_test;
  import c2s_pkg::*;

  localparam int CW = 32;
  localparam int AW = 16;
  localparam int STAGES = 16;
  localparam int GUARD = 24;
  localparam int N_RANDOM = 710;
  localparam int LATENCY = 60;
  localparam longint CYCLE_LIMIT = 400000;
  localparam logic signed [CW-1:0] CMAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;
  localparam longint PI_ACC = 64'sd2147483648;

  typedef struct {
    logic [31:0]          radius;
    logic signed [AW-1:0] azimuth;
    logic [AW-1:0]        inclination;
    logic                 degenerate;
  } sph_t;

  typedef struct {
    logic signed [CW-1:0] x, y, z;
    bit                   typed;
    sph_t                 res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [CW-1:0] x_coord_i = '0, y_coord_i = '0, z_coord_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [31:0] radius_o;
  logic signed [AW-1:0] azimuth_o;
  logic [AW-1:0] inclination_o;
  logic degenerate_o;

  sph_t pending_points[$];
  int fail_count = 0;
  longint cycle_count = 0;
  bit rx_idle_allowed = 1'b1;
  bit rx_hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  cartesian_to_spherical_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .x_coord_i, .y_coord_i, .z_coord_i,
    .out_valid_o, .out_ready_i, .radius_o, .azimuth_o, .inclination_o, .degenerate_o
  );

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring cordic, angle in units of pi/2^31, not wrapped
  function automatic longint vector_angle(longint px, longint py);
    longint acc, cx, cy, dx, dy;
    acc = 0;
    cx = px;
    cy = py;
    if (cx < 0) begin
      cx = -cx;
      cy = -cy;
      acc = PI_ACC;
    end
    cx = cx <<< GUARD;
    cy = cy <<< GUARD;
    for (int i = 0; i < STAGES; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx;
        cy -= dy;
        acc += longint'(atan_step(i));
      end else begin
        cx -= dx;
        cy += dy;
        acc -= longint'(atan_step(i));
      end
    end
    return acc;
  endfunction

  function automatic logic [AW-1:0] angle_round(longint a);
    logic [63:0] t;
    t = 64'(a) + (64'd1 << (31 - AW));
    return AW'(t >> (32 - AW));
  endfunction

  function automatic sph_t to_spherical(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                        logic signed [CW-1:0] z);
    longint sx, sy, sz, az, inc;
    logic [63:0] mx, my, mz, sq_xy, rho;
    sph_t r;
    sx = x;
    sy = y;
    sz = z;
    mx = sx < 0 ? -sx : sx;
    my = sy < 0 ? -sy : sy;
    mz = sz < 0 ? -sz : sz;
    sq_xy = mx * mx + my * my;
    r.radius = 32'(int_sqrt(sq_xy + mz * mz));
    rho = int_sqrt(sq_xy);
    if (sy == 0) az = (sx < 0) ? PI_ACC : 0;
    else az = vector_angle(sx, sy);
    r.degenerate = 1'b0;
    if (rho == 0) begin
      inc = (sz < 0) ? PI_ACC : 0;
      r.degenerate = (sz == 0);
    end else begin
      inc = vector_angle(sz, longint'(rho));
      if (inc < 0) inc = 0;
      if (inc > PI_ACC) inc = PI_ACC;
    end
    r.azimuth = angle_round(az);
    r.inclination = angle_round(inc);
    return r;
  endfunction

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CW'($urandom_range(0, 3)) - 1;
      1: return $urandom_range(0, 1) ? CMAX : CMIN;
      2: return $signed(CW'($urandom_range(0, 32'h0003_FFFF))) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  // one transfer on the input channel; the expectation is queued at acceptance
  task automatic send_point(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                            logic signed [CW-1:0] z, bit typed, sph_t res, bit idle_ok);
    while (idle_ok && $urandom_range(0, 99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_coord_i <= x;
    y_coord_i <= y;
    z_coord_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    pending_points.insert(pending_points.size(), typed ? res : to_spherical(x, y, z));
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random backpressure, with a long hold on request
  initial begin
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        for (hold = 0; hold < 200; hold++) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      out_ready_i <= !(rx_idle_allowed && $urandom_range(0, 99) < 38);
    end
  end

  // result checker, sampled at the edge where the transfer happens
  always @(posedge clk_i) begin
    sph_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_points.size() == 0) begin
        $error("result with no point pending");
        fail_count++;
      end else begin
        e = pending_points.pop_front();
        if (radius_o !== e.radius) begin
          $error("radius exp %0d got %0d", e.radius, radius_o);
          fail_count++;
        end
        if (azimuth_o !== e.azimuth) begin
          $error("azimuth exp %0d got %0d", e.azimuth, azimuth_o);
          fail_count++;
        end
        if (inclination_o !== e.inclination) begin
          $error("inclination exp %0d got %0d", e.inclination, inclination_o);
          fail_count++;
        end
        if (degenerate_o !== e.degenerate) begin
          $error("degenerate exp %0d got %0d", e.degenerate, degenerate_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    sph_t none;
    logic signed [CW-1:0] a, b;
    none = '{default: '0};
    // origin, x and z axis points and extremes typed in; the rest go to the predictor
    rows = '{
      '{0, 0, 0, 1, '{0, 0, 0, 1}},
      '{32'sh10000, 0, 0, 1, '{32'h10000, 0, 16'd16384, 0}},
      '{-32'sh10000, 0, 0, 1, '{32'h10000, -16'sd32768, 16'd16384, 0}},
      '{0, 0, 32'sh10000, 1, '{32'h10000, 0, 0, 0}},
      '{0, 0, -32'sh10000, 1, '{32'h10000, 0, 16'd32768, 0}},
      '{0, 0, CMIN, 1, '{32'h8000_0000, 0, 16'd32768, 0}},
      '{CMAX, 0, 0, 1, '{32'h7FFF_FFFF, 0, 16'd16384, 0}},
      '{CMIN, 0, 0, 1, '{32'h8000_0000, -16'sd32768, 16'd16384, 0}},
      '{0, CMAX, 0, 0, none}, '{0, CMIN, 0, 0, none},
      '{CMIN, CMIN, CMIN, 0, none}, '{CMAX, CMAX, CMAX, 0, none},
      '{CMAX, CMIN, CMAX, 0, none}, '{CMIN, CMAX, CMIN, 0, none},
      '{1, 1, 1, 0, none}, '{-1, -1, -1, 0, none}, '{-1, 1, 0, 0, none},
      '{1, -1, 0, 0, none}, '{0, 1, -1, 0, none}, '{32'sh30000, 32'sh40000, 0, 0, none},
      '{-32'sh30000, -32'sh40000, 32'sh50000, 0, none}
    };
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      rw = rows[i];
      send_point(rw.x, rw.y, rw.z, rw.typed, rw.res, 1'b1);
    end
    in_valid_i <= 1'b0;
    // sender pauses until the pipeline has emptied
    wait_drained();
    // long receiver hold while the sender keeps offering points back to back
    rx_hold_req = 1'b1;
    for (int n = 0; n < 120; n++)
      send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none, 1'b0);
    // random points, with a stretch of no idling on either side in the middle
    for (int n = 0; n < N_RANDOM; n++) begin
      rx_idle_allowed = !(n >= 300 && n < 450);
      if ($urandom_range(0, 9) == 0) begin
        a = $urandom_range(0, 1) ? 0 : rand_coord();
        b = $urandom_range(0, 1) ? 0 : rand_coord();
        send_point(a, b, rand_coord(), 1'b0, none, rx_idle_allowed);
      end else begin
        send_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, none, rx_idle_allowed);
      end
    end
    in_valid_i <= 1'b0;
    rx_idle_allowed = 1'b1;
    wait_drained();
    repeat (LATENCY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
